@@ src/sbsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit package
// Shared constants, types and helpers for the sprite compositor.
// ----------------------------------------------------------------------------
package sbsc_pkg;

    localparam int SCREEN_COLS = 512;
    localparam int SCREEN_ROWS = 256;
    localparam int MAX_SPRITE  = 64;

    localparam int COL_W   = $clog2(SCREEN_COLS);
    localparam int ROW_W   = $clog2(SCREEN_ROWS);
    localparam int ADDR_W  = $clog2(SCREEN_COLS * SCREEN_ROWS);
    localparam int CNT_W   = $clog2(MAX_SPRITE);
    localparam int SAVE_AW = $clog2(MAX_SPRITE * MAX_SPRITE);
    localparam int SIZE_W  = 7;
    localparam int PIX_W   = 8;

    typedef enum logic [2:0] {
        OP_BEGIN_DRAW    = 3'd0,
        OP_DRAW_PIXEL    = 3'd1,
        OP_BEGIN_RESTORE = 3'd2,
        OP_RESTORE_PIXEL = 3'd3,
        OP_READ_SCREEN   = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ISSUE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic rd_en;
        logic commit;
        logic clear_wr;
    } ctrl_t;

    // A size of zero becomes one, anything above the largest sprite is capped.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] r;
        if (v == '0)
        begin
            r = SIZE_W'(1);
        end
        else if (v > SIZE_W'(MAX_SPRITE))
        begin
            r = SIZE_W'(MAX_SPRITE);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ src/sbsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module sbsc_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 12
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/sbsc_fsm.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit sequencer
// Runs the frame store clearing pass, then steps each word through
// read and commit.
// ----------------------------------------------------------------------------
module sbsc_fsm
    import sbsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              out_free,
    output ctrl_t             ctrl,
    output logic [ADDR_W-1:0] clr_addr
);

    state_t            state_reg;
    state_t            state_next;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] clr_addr_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        clr_addr_next = clr_addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ctrl.clear_wr = 1'b1;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
            end
            ST_IDLE:
            begin
                ctrl.in_ready = 1'b1;
            end
            ST_ISSUE:
            begin
                ctrl.rd_en = 1'b1;
            end
            ST_COMMIT:
            begin
                ctrl.commit = out_free;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    assign clr_addr = clr_addr_reg;

endmodule

@@ src/sprite_blit_save_collide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit with background save and collision detection
// Composites sprites into a wrapping 8-bit frame store, saves and restores
// the background, and latches the first collision of each draw.
// ----------------------------------------------------------------------------
// Flow: a word is taken in IDLE, read in ISSUE and written back in COMMIT,
// which also loads the result word into the output register and waits while
// that register is full and not taken; the next word is taken only after commit.
// Reset: after rst_n rises the frame store is swept to zero, one pixel per
// cycle; no input word is taken during that pass.
// All control and sprite state returns to its reset value at once.
module sprite_blit_save_collide
    import sbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: pos_col[8:0], pos_row[16:9], sprite_width[23:17],
    // sprite_height[30:24], overwrite[31], pixel[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: op[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: collided[0], hit_col[10:1], hit_row[19:11],
    // read_pixel[27:20], zero fill [31:28]
    output logic [31:0] m_axis_tdata,
    // tlast: run_last
    output logic        m_axis_tlast
);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    ctrl_t             ctrl;
    logic [ADDR_W-1:0] clr_addr;
    logic              out_free;
    logic              out_valid_reg;

    assign out_free = !out_valid_reg || m_axis_tready;

    sbsc_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .out_free (out_free),
        .ctrl     (ctrl),
        .clr_addr (clr_addr)
    );

    assign s_axis_tready = ctrl.in_ready;

    // ------------------------------------------------------------------
    // Captured input word. Payload only, so no reset is needed.
    // ------------------------------------------------------------------
    logic [2:0]        op_reg;
    logic [8:0]        pos_col_reg;
    logic [7:0]        pos_row_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    logic              overwrite_reg;
    logic [PIX_W-1:0]  pixel_reg;

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            op_reg        <= s_axis_tuser;
            pos_col_reg   <= s_axis_tdata[8:0];
            pos_row_reg   <= s_axis_tdata[16:9];
            width_reg     <= s_axis_tdata[23:17];
            height_reg    <= s_axis_tdata[30:24];
            overwrite_reg <= s_axis_tdata[31];
            pixel_reg     <= s_axis_tdata[39:32];
        end
    end

    // ------------------------------------------------------------------
    // Sprite walk state
    // ------------------------------------------------------------------
    logic [8:0]        origin_col_reg,  origin_col_next;
    logic [7:0]        origin_row_reg,  origin_row_next;
    logic [SIZE_W-1:0] rect_width_reg,  rect_width_next;
    logic [SIZE_W-1:0] rect_height_reg, rect_height_next;
    logic [CNT_W-1:0]  col_count_reg,   col_count_next;
    logic [CNT_W-1:0]  row_count_reg,   row_count_next;
    logic              clash_flag_reg,  clash_flag_next;
    logic [9:0]        clash_col_reg,   clash_col_next;
    logic [8:0]        clash_row_reg,   clash_row_next;
    logic              overwrite_mode_reg, overwrite_mode_next;

    // Unwrapped position of the current sprite pixel. The column and row reach
    // past the screen edge by less than one sprite width; the frame address
    // wraps them, the collision latch keeps them as is.
    logic [9:0]        ucol;
    logic [8:0]        urow;
    logic [COL_W-1:0]  wcol;
    logic [ROW_W-1:0]  wrow;
    logic [ADDR_W-1:0] draw_addr;
    logic [ADDR_W-1:0] read_addr;
    logic [SAVE_AW-1:0] save_addr;

    assign ucol = {1'b0, origin_col_reg} + 10'(col_count_reg);
    assign urow = {1'b0, origin_row_reg} + 9'(row_count_reg);
    assign wcol = COL_W'(ucol % SCREEN_COLS);
    assign wrow = ROW_W'(urow % SCREEN_ROWS);
    assign draw_addr = ADDR_W'(ADDR_W'(wrow) * SCREEN_COLS + ADDR_W'(wcol));
    assign read_addr = ADDR_W'(ADDR_W'(ROW_W'(pos_row_reg % SCREEN_ROWS)) * SCREEN_COLS
                              + ADDR_W'(COL_W'(pos_col_reg % SCREEN_COLS)));
    assign save_addr = SAVE_AW'(SAVE_AW'(row_count_reg) * MAX_SPRITE
                                + SAVE_AW'(col_count_reg));

    // ------------------------------------------------------------------
    // Frame store and background save store
    // ------------------------------------------------------------------
    logic              scr_wr_en;
    logic [ADDR_W-1:0] scr_wr_addr;
    logic [PIX_W-1:0]  scr_wr_data;
    logic [ADDR_W-1:0] scr_rd_addr;
    logic [PIX_W-1:0]  scr_rd_data;
    logic              sav_wr_en;
    logic [PIX_W-1:0]  sav_rd_data;

    assign scr_rd_addr = (op_reg == OP_READ_SCREEN) ? read_addr : draw_addr;

    sbsc_ram #(
        .DATA_W (PIX_W),
        .ADDR_W (ADDR_W)
    ) u_screen_ram (
        .clk     (clk),
        .wr_en   (scr_wr_en),
        .wr_addr (scr_wr_addr),
        .wr_data (scr_wr_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (scr_rd_addr),
        .rd_data (scr_rd_data)
    );

    sbsc_ram #(
        .DATA_W (PIX_W),
        .ADDR_W (SAVE_AW)
    ) u_save_ram (
        .clk     (clk),
        .wr_en   (sav_wr_en),
        .wr_addr (save_addr),
        .wr_data (scr_rd_data),
        .rd_en   (ctrl.rd_en),
        .rd_addr (save_addr),
        .rd_data (sav_rd_data)
    );

    // ------------------------------------------------------------------
    // Commit: the pixel read in the issue state is composited and
    // written back, the walk advances and the result word is formed.
    // ------------------------------------------------------------------
    logic              col_wrap;
    logic              row_wrap;
    logic              run_last;
    logic [PIX_W-1:0]  read_pixel;

    assign col_wrap = !((SIZE_W'(col_count_reg) + SIZE_W'(1)) < rect_width_reg);
    assign row_wrap = !((SIZE_W'(row_count_reg) + SIZE_W'(1)) < rect_height_reg);

    always_comb
    begin
        origin_col_next     = origin_col_reg;
        origin_row_next     = origin_row_reg;
        rect_width_next     = rect_width_reg;
        rect_height_next    = rect_height_reg;
        col_count_next      = col_count_reg;
        row_count_next      = row_count_reg;
        clash_flag_next     = clash_flag_reg;
        clash_col_next      = clash_col_reg;
        clash_row_next      = clash_row_reg;
        overwrite_mode_next = overwrite_mode_reg;
        scr_wr_en           = 1'b0;
        scr_wr_addr         = draw_addr;
        scr_wr_data         = pixel_reg;
        sav_wr_en           = 1'b0;
        run_last            = 1'b0;
        read_pixel          = '0;

        if (ctrl.clear_wr)
        begin
            scr_wr_en   = 1'b1;
            scr_wr_addr = clr_addr;
            scr_wr_data = '0;
        end
        else if (ctrl.commit)
        begin
            case (op_reg)
                OP_BEGIN_DRAW:
                begin
                    origin_col_next     = pos_col_reg;
                    origin_row_next     = pos_row_reg;
                    rect_width_next     = clamp_size(width_reg);
                    rect_height_next    = clamp_size(height_reg);
                    overwrite_mode_next = overwrite_reg;
                    col_count_next      = '0;
                    row_count_next      = '0;
                    clash_flag_next     = 1'b0;
                    clash_col_next      = '0;
                    clash_row_next      = '0;
                end
                OP_DRAW_PIXEL, OP_RESTORE_PIXEL:
                begin
                    if (op_reg == OP_DRAW_PIXEL)
                    begin
                        sav_wr_en = 1'b1;
                        if (pixel_reg != '0)
                        begin
                            if (overwrite_mode_reg || scr_rd_data == '0)
                            begin
                                scr_wr_en = 1'b1;
                            end
                            else if (!clash_flag_reg)
                            begin
                                clash_flag_next = 1'b1;
                                clash_col_next  = ucol;
                                clash_row_next  = urow;
                            end
                        end
                    end
                    else
                    begin
                        scr_wr_en   = 1'b1;
                        scr_wr_data = sav_rd_data;
                    end
                    // Row-major walk; past the last pixel it starts over.
                    if (!col_wrap)
                    begin
                        col_count_next = col_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        col_count_next = '0;
                        if (!row_wrap)
                        begin
                            row_count_next = row_count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            row_count_next = '0;
                            run_last       = 1'b1;
                        end
                    end
                end
                OP_BEGIN_RESTORE:
                begin
                    col_count_next = '0;
                    row_count_next = '0;
                end
                OP_READ_SCREEN:
                begin
                    read_pixel = scr_rd_data;
                end
                default:
                begin
                    // Unused codes only report the status.
                    run_last = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_col_reg     <= '0;
            origin_row_reg     <= '0;
            rect_width_reg     <= SIZE_W'(1);
            rect_height_reg    <= SIZE_W'(1);
            col_count_reg      <= '0;
            row_count_reg      <= '0;
            clash_flag_reg     <= 1'b0;
            clash_col_reg      <= '0;
            clash_row_reg      <= '0;
            overwrite_mode_reg <= 1'b0;
        end
        else
        begin
            origin_col_reg     <= origin_col_next;
            origin_row_reg     <= origin_row_next;
            rect_width_reg     <= rect_width_next;
            rect_height_reg    <= rect_height_next;
            col_count_reg      <= col_count_next;
            row_count_reg      <= row_count_next;
            clash_flag_reg     <= clash_flag_next;
            clash_col_reg      <= clash_col_next;
            clash_row_reg      <= clash_row_next;
            overwrite_mode_reg <= overwrite_mode_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register. The result word sits here until the sink takes it;
    // the next input word can already be taken and read meanwhile.
    // ------------------------------------------------------------------
    logic [31:0] out_data_reg;
    logic        out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_data_reg <= {4'b0000, read_pixel, clash_row_next, clash_col_next,
                             clash_flag_next};
            out_last_reg <= run_last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear_wr |-> !s_axis_tready)
        else $error("input taken during frame store clearing pass");

    a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> ctrl.rd_en)
        else $error("accepted word did not start a memory read");

    a_commit_gives_word: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.commit |=> m_axis_tvalid)
        else $error("commit did not present a result word");

    a_hit_zero_without_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[19:1] == '0))
        else $error("collision coordinates set without collision flag");

endmodule

@@ test/sbsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit checker
// Watches both stream channels of the sprite compositor, keeps its own frame
// and background stores, and compares every result word with its prediction.
// ----------------------------------------------------------------------------
module sbsc_checker
    import sbsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // tdata, low bit up: pos_col, pos_row, sprite_width, sprite_height,
    // overwrite, pixel
    input  logic [39:0] s_axis_tdata,
    // tuser: op
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata, low bit up: collided, hit_col, hit_row, read_pixel, zero fill
    input  logic [31:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int unsigned errors,
    output int unsigned pending,
    output int unsigned checked
);

    typedef struct packed {
        logic        run_last;
        logic        collided;
        logic [9:0]  hit_col;
        logic [8:0]  hit_row;
        logic [7:0]  read_pixel;
    } blit_status_t;

    bit [PIX_W-1:0] frame_mem  [SCREEN_COLS*SCREEN_ROWS];
    bit [PIX_W-1:0] backup_mem [MAX_SPRITE*MAX_SPRITE];

    int unsigned org_col = 0;
    int unsigned org_row = 0;
    int unsigned rect_w  = 1;
    int unsigned rect_h  = 1;
    int unsigned walk_c  = 0;
    int unsigned walk_r  = 0;
    int unsigned hit_c   = 0;
    int unsigned hit_r   = 0;
    bit          hit     = 1'b0;
    bit          ow_mode = 1'b0;

    blit_status_t status_q[$];
    int unsigned  err_tally   = 0;
    int unsigned  check_tally = 0;

    function automatic int unsigned clip_size(input logic [SIZE_W-1:0] v);
        if (v == '0)
        begin
            return 1;
        end
        if (v > MAX_SPRITE)
        begin
            return MAX_SPRITE;
        end
        return v;
    endfunction

    // Applies one accepted word to the shadow state and queues its status.
    task automatic predict_word(input logic [2:0] op, input logic [39:0] d);
        blit_status_t r;
        int unsigned  ucol;
        int unsigned  urow;
        int unsigned  addr;
        int unsigned  sidx;
        logic [7:0]   pix;
        r    = '0;
        pix  = d[39:32];
        ucol = org_col + walk_c;
        urow = org_row + walk_r;
        addr = (ucol % SCREEN_COLS) + (urow % SCREEN_ROWS) * SCREEN_COLS;
        sidx = walk_r * MAX_SPRITE + walk_c;
        case (op)
            OP_BEGIN_DRAW:
            begin
                org_col = d[8:0];
                org_row = d[16:9];
                rect_w  = clip_size(d[23:17]);
                rect_h  = clip_size(d[30:24]);
                ow_mode = d[31];
                walk_c  = 0;
                walk_r  = 0;
                hit     = 1'b0;
                hit_c   = 0;
                hit_r   = 0;
            end
            OP_DRAW_PIXEL, OP_RESTORE_PIXEL:
            begin
                if (op == OP_DRAW_PIXEL)
                begin
                    backup_mem[sidx] = frame_mem[addr];
                    if (pix != 0)
                    begin
                        if (ow_mode || frame_mem[addr] == 0)
                        begin
                            frame_mem[addr] = pix;
                        end
                        else if (!hit)
                        begin
                            hit   = 1'b1;
                            hit_c = ucol;
                            hit_r = urow;
                        end
                    end
                end
                else
                begin
                    frame_mem[addr] = backup_mem[sidx];
                end
                if (walk_c + 1 < rect_w)
                begin
                    walk_c++;
                end
                else
                begin
                    walk_c = 0;
                    if (walk_r + 1 < rect_h)
                    begin
                        walk_r++;
                    end
                    else
                    begin
                        walk_r     = 0;
                        r.run_last = 1'b1;
                    end
                end
            end
            OP_BEGIN_RESTORE:
            begin
                walk_c = 0;
                walk_r = 0;
            end
            OP_READ_SCREEN:
            begin
                r.read_pixel = frame_mem[(d[8:0] % SCREEN_COLS) +
                                         (d[16:9] % SCREEN_ROWS) * SCREEN_COLS];
            end
            default:
            begin
            end
        endcase
        r.collided = hit;
        r.hit_col  = 10'(hit_c);
        r.hit_row  = 9'(hit_r);
        status_q.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_tally++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        blit_status_t want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_word(s_axis_tuser, s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (status_q.size() == 0)
                begin
                    $error("result word with nothing pending: tdata %h tlast %b",
                           m_axis_tdata, m_axis_tlast);
                    err_tally++;
                end
                else
                begin
                    want = status_q.pop_front();
                    check_tally++;
                    check_field("run_last", want.run_last, m_axis_tlast);
                    check_field("collided", want.collided, m_axis_tdata[0]);
                    check_field("hit_col", want.hit_col, m_axis_tdata[10:1]);
                    check_field("hit_row", want.hit_row, m_axis_tdata[19:11]);
                    check_field("read_pixel", want.read_pixel, m_axis_tdata[27:20]);
                    check_field("zero fill", 0, m_axis_tdata[31:28]);
                end
            end
        end
        errors  <= err_tally;
        pending <= status_q.size();
        checked <= check_tally;
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sprite blit testbench
// Drives draw, restore and read words into the sprite compositor with random
// gaps and back-pressure, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module testbench;
    import sbsc_pkg::*;

    // Op codes above the last defined operation; the block must ignore them.
    localparam logic [2:0] OP_SPARE_LO = 3'd5;
    localparam logic [2:0] OP_SPARE_HI = 3'd7;

    localparam int MAX_WAIT     = 18;
    localparam int WORD_TARGET  = 1600;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_LOOSE_RESTORE = 16;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;
    logic [2:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    int unsigned fail_count;
    int unsigned pending_results;
    int unsigned results_checked;

    // When a side is calm it neither idles nor stalls; each side flips its
    // mode now and then so that long back-to-back stretches also occur.
    bit sender_calm = 1'b0;
    bit sink_calm   = 1'b0;

    // Stimulus-side view of the rectangle walk. It keeps restore words on
    // background entries that some draw has already saved, aims reads at the
    // sprite just drawn, and sizes the pixel rasters.
    bit          saved_ok [MAX_SPRITE*MAX_SPRITE];
    int unsigned trk_oc = 0;
    int unsigned trk_or = 0;
    int unsigned trk_w  = 1;
    int unsigned trk_h  = 1;
    int unsigned trk_c  = 0;
    int unsigned trk_r  = 0;

    int unsigned word_count = 0;
    int unsigned n_begin    = 0;
    int unsigned n_draw     = 0;
    int unsigned n_restore  = 0;
    int unsigned n_read     = 0;
    int unsigned n_spare    = 0;

    sprite_blit_save_collide u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    sbsc_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .errors        (fail_count),
        .pending       (pending_results),
        .checked       (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The reset sweep of the frame store alone takes about 1.3 ms; the
    // slowest legal run of the words adds well under 1 ms on top of that.
    initial
    begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic int unsigned pick_wait(input bit calm);
        if (calm || $urandom_range(0, 1) == 0)
        begin
            return 0;
        end
        return $urandom_range(1, MAX_WAIT);
    endfunction

    // Sprite colours: plenty of transparent zeros, some all-ones.
    function automatic logic [7:0] rand_pixel();
        int unsigned k;
        k = $urandom_range(0, 19);
        if (k < 7)
        begin
            return 8'h00;
        end
        if (k == 7)
        begin
            return 8'hFF;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    // Sends one word. Valid stays high across back-to-back words and is only
    // lowered when a gap is drawn, so each step sees one assignment at most.
    task automatic send_word(input logic [2:0] op, input logic [39:0] d);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
        begin
            sender_calm = !sender_calm;
        end
        gap = pick_wait(sender_calm);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= op;
        do @(posedge clk); while (!s_axis_tready);

        if (op <= OP_READ_SCREEN)
        begin
            word_count++;
        end
        case (op)
            OP_BEGIN_DRAW:
            begin
                trk_oc = d[8:0];
                trk_or = d[16:9];
                trk_w  = (d[23:17] == 0) ? 1 :
                         (d[23:17] > MAX_SPRITE) ? MAX_SPRITE : d[23:17];
                trk_h  = (d[30:24] == 0) ? 1 :
                         (d[30:24] > MAX_SPRITE) ? MAX_SPRITE : d[30:24];
                trk_c  = 0;
                trk_r  = 0;
                n_begin++;
            end
            OP_DRAW_PIXEL:
            begin
                saved_ok[trk_r * MAX_SPRITE + trk_c] = 1'b1;
                n_draw++;
            end
            OP_RESTORE_PIXEL:
            begin
                n_restore++;
            end
            OP_BEGIN_RESTORE:
            begin
                trk_c = 0;
                trk_r = 0;
                n_begin++;
            end
            OP_READ_SCREEN:
            begin
                n_read++;
            end
            default:
            begin
                n_spare++;
            end
        endcase
        // Draw and restore pixels both step through the rectangle.
        if (op == OP_DRAW_PIXEL || op == OP_RESTORE_PIXEL)
        begin
            if (trk_c + 1 < trk_w)
            begin
                trk_c++;
            end
            else
            begin
                trk_c = 0;
                trk_r = (trk_r + 1 < trk_h) ? trk_r + 1 : 0;
            end
        end
    endtask

    // Unused fields of every word carry random bits so that each input bit
    // toggles regardless of the operation mix.
    task automatic begin_draw(input int unsigned col, input int unsigned row,
                              input int unsigned w, input int unsigned h,
                              input bit ow);
        send_word(OP_BEGIN_DRAW, {8'($urandom), ow, 7'(h), 7'(w), 8'(row), 9'(col)});
    endtask

    task automatic draw_px(input logic [7:0] pix);
        send_word(OP_DRAW_PIXEL, {pix, 32'($urandom)});
    endtask

    task automatic begin_restore();
        send_word(OP_BEGIN_RESTORE, {8'($urandom), 32'($urandom)});
    endtask

    // Reads wrap on the screen size simply by truncation to the field width.
    task automatic read_px(input int unsigned col, input int unsigned row);
        send_word(OP_READ_SCREEN, {8'($urandom), 1'($urandom), 7'($urandom),
                                   7'($urandom), 8'(row), 9'(col)});
    endtask

    // A restore of a background entry that no draw has saved has no defined
    // result, so such a word is replaced by a read at a random spot.
    task automatic restore_px();
        if (saved_ok[trk_r * MAX_SPRITE + trk_c])
        begin
            send_word(OP_RESTORE_PIXEL, {8'($urandom), 32'($urandom)});
        end
        else
        begin
            read_px($urandom_range(0, 511), $urandom_range(0, 255));
        end
    endtask

    task automatic spare_word();
        send_word(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)),
                  {8'($urandom), 32'($urandom)});
    endtask

    // Holds the sender back until the checker has seen every result. The
    // loop waits on the clock before it tests, so valid is never lowered and
    // raised within the same step.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic reads_in_sprite(input int unsigned count);
        repeat (count)
        begin
            read_px(trk_oc + $urandom_range(0, trk_w - 1),
                    trk_or + $urandom_range(0, trk_h - 1));
        end
    endtask

    // A mostly well-formed blit: begin, a raster of pixels, a few reads, then
    // usually a restore of the background. Origins cluster in two hot spots,
    // one at the wrapping corner, so sprites overlap and collide often.
    task automatic draw_scene();
        int unsigned col;
        int unsigned row;
        int unsigned w;
        int unsigned h;
        int unsigned npx;
        int unsigned k;
        bit          ow;
        k = $urandom_range(0, 9);
        if (k < 4)
        begin
            col = $urandom_range(500, 511);
            row = $urandom_range(245, 255);
        end
        else if (k < 8)
        begin
            col = $urandom_range(100, 115);
            row = $urandom_range(60, 75);
        end
        else
        begin
            col = $urandom_range(0, 511);
            row = $urandom_range(0, 255);
        end
        // Mostly small sprites; long thin ones reach the largest size and the
        // clamp, and zero sizes check the lower clamp.
        k = $urandom_range(0, 19);
        if (k < 17)
        begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
        end
        else if (k == 17)
        begin
            w = $urandom_range(9, 127);
            h = $urandom_range(0, 2);
        end
        else if (k == 18)
        begin
            w = $urandom_range(0, 2);
            h = $urandom_range(9, 127);
        end
        else
        begin
            w = $urandom_range(0, 1);
            h = $urandom_range(0, 1);
        end
        ow = ($urandom_range(0, 3) == 0);
        begin_draw(col, row, w, h, ow);

        // Sometimes the raster is cut short or runs past its end.
        npx = trk_w * trk_h;
        k   = $urandom_range(0, 9);
        if (k == 0)
        begin
            npx = $urandom_range(1, npx);
        end
        else if (k == 1)
        begin
            npx += $urandom_range(1, 3);
        end
        repeat (npx) draw_px(rand_pixel());
        reads_in_sprite($urandom_range(0, 2));

        if ($urandom_range(0, 9) < 6)
        begin
            begin_restore();
            npx = ($urandom_range(0, 3) == 0) ? $urandom_range(1, trk_w * trk_h)
                                              : trk_w * trk_h;
            repeat (npx) restore_px();
            reads_in_sprite($urandom_range(0, 2));
        end
    endtask

    // Short runs of arbitrary words, including unused op codes, restarts in
    // the middle of a raster and huge rectangles that are never finished.
    task automatic noise_scene();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(0, 7))
                0: begin_draw($urandom_range(0, 511), $urandom_range(0, 255),
                              $urandom_range(0, 127), $urandom_range(0, 127),
                              1'($urandom));
                1: draw_px(rand_pixel());
                2: begin_restore();
                3: restore_px();
                4: read_px($urandom_range(0, 511), $urandom_range(0, 255));
                default: spare_word();
            endcase
        end
    endtask

    // The sink may hold tready low for a random wait before each result word.
    initial
    begin : sink
        int unsigned stall;
        forever
        begin
            if ($urandom_range(0, 31) == 0)
            begin
                sink_calm = !sink_calm;
            end
            stall = pick_wait(sink_calm);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : stimulus
        int unsigned k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The store must read back zero after the clearing
        // pass, at both corners.
        read_px(0, 0);
        read_px(511, 255);
        // A 2x2 sprite at the bottom right corner wraps on both axes. The
        // second one lands on the first: a transparent pixel, a write onto
        // zero, a clash whose unwrapped position lies off screen, and a second
        // clash that must not move the latched position.
        begin_draw(511, 255, 2, 2, 1'b0);
        draw_px(8'hFF);
        draw_px(8'h00);
        draw_px(8'h01);
        draw_px(8'h80);
        begin_draw(511, 255, 2, 2, 1'b0);
        draw_px(8'h00);
        draw_px(8'h07);
        draw_px(8'h07);
        draw_px(8'h07);
        // Restore puts the first sprite back; the collision stays latched.
        begin_restore();
        repeat (4) restore_px();
        read_px(511, 255);
        read_px(0, 0);
        // Zero sizes become 1x1; overwrite replaces a nonzero pixel without
        // a clash, and the extra pixel past the end starts over.
        begin_draw(511, 255, 0, 0, 1'b1);
        draw_px(8'd200);
        draw_px(8'd33);
        read_px(511, 255);
        spare_word();
        wait_drained();

        // Random part, mostly well-formed blits.
        while (word_count < WORD_TARGET)
        begin
            k = $urandom_range(0, 99);
            if (k < 60)
            begin
                draw_scene();
            end
            else if (k < 72)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    read_px(trk_oc + $urandom_range(0, 15), trk_or + $urandom_range(0, 15));
                end
            end
            else if (k < 88)
            begin
                noise_scene();
            end
            else if (k < 95)
            begin
                // A loose restore stays short even after a huge rectangle.
                begin_restore();
                repeat ($urandom_range(1, (trk_w * trk_h < MAX_LOOSE_RESTORE) ?
                                          trk_w * trk_h : MAX_LOOSE_RESTORE))
                    restore_px();
            end
            else
            begin
                wait_drained();
            end
        end

        // Let every result come back, then give the pipe a few idle cycles.
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d words: %0d begins, %0d draw pixels, %0d restore pixels, %0d reads",
                 word_count, n_begin, n_draw, n_restore, n_read);
        $display("plus %0d ignored op codes; %0d result words compared with prediction",
                 n_spare, results_checked);
        if (fail_count == 0 && pending_results == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
